// ===== hw/rtl/serial_camera_capture_host_unit_defines.svh =====
// Assertion macros shared by the checker files.
// Both macros sample on the rising edge of clock.
`ifndef SERIAL_CAMERA_CAPTURE_HOST_UNIT_DEFINES_SVH
`define SERIAL_CAMERA_CAPTURE_HOST_UNIT_DEFINES_SVH

// Checked outside reset only.
`define SCCH_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("serial camera host: assertion failed");

// Checked in every cycle, reset included.
`define SCCH_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("serial camera host: assertion failed");

`endif

// ===== hw/rtl/scch_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scch_pkg
// Types, codes and reply tables of the serial camera capture host.
// ----------------------------------------------------------------------------
package scch_pkg;

   // input opcodes
   localparam logic [1:0] OP_SYNC    = 2'd0;
   localparam logic [1:0] OP_CAPTURE = 2'd1;
   localparam logic [1:0] OP_NEXT    = 2'd2;
   localparam logic [1:0] OP_RX      = 2'd3;

   // result kinds
   localparam logic [1:0] KIND_TX    = 2'd0;
   localparam logic [1:0] KIND_DATA  = 2'd1;
   localparam logic [1:0] KIND_EVENT = 2'd2;

   // status events
   localparam logic [2:0] EV_NONE      = 3'd0;
   localparam logic [2:0] EV_READY     = 3'd1;
   localparam logic [2:0] EV_SIZE_ZERO = 3'd2;
   localparam logic [2:0] EV_PACKAGE   = 3'd3;
   localparam logic [2:0] EV_IMAGE     = 3'd4;
   localparam logic [2:0] EV_REFUSED   = 3'd5;

   // register indexes
   localparam logic [1:0] REG_COLOR_FORMAT    = 2'd0;
   localparam logic [1:0] REG_RAW_RESOLUTION  = 2'd1;
   localparam logic [1:0] REG_JPEG_RESOLUTION = 2'd2;
   localparam logic [1:0] REG_PACKAGE_PAYLOAD = 2'd3;

   // protocol phases
   localparam logic [3:0] PH_IDLE     = 4'd0;
   localparam logic [3:0] PH_SYNC_ACK = 4'd1;
   localparam logic [3:0] PH_SYNC_EXT = 4'd2;
   localparam logic [3:0] PH_INIT_ACK = 4'd3;
   localparam logic [3:0] PH_PACK_ACK = 4'd4;
   localparam logic [3:0] PH_SNAP_ACK = 4'd5;
   localparam logic [3:0] PH_PIC_ACK  = 4'd6;
   localparam logic [3:0] PH_SIZE     = 4'd7;
   localparam logic [3:0] PH_READY    = 4'd8;
   localparam logic [3:0] PH_STREAM   = 4'd9;

   localparam int CMD_LEN     = 6;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] BYTE_SYNC_HDR = 8'hAA;
   localparam logic [7:0] ID_INITIAL    = 8'h01;
   localparam logic [7:0] ID_GET_PIC    = 8'h04;
   localparam logic [7:0] ID_SNAPSHOT   = 8'h05;
   localparam logic [7:0] ID_PKG_SIZE   = 8'h06;
   localparam logic [7:0] ID_SYNC       = 8'h0D;
   localparam logic [7:0] ID_ACK        = 8'h0E;
   localparam logic [7:0] BYTE_SYNC_OK  = 8'hF5;
   localparam logic [7:0] BYTE_BYE      = 8'hF0;

   typedef logic [CMD_LEN-1:0][7:0] cmd_type;   // [0] goes out first

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  out_kind;
      logic [7:0]  out_byte;
      logic [2:0]  event_code;
      logic [23:0] image_length;
      logic        run_last;
   } rsp_type;

   typedef struct packed {
      logic [7:0] color_format;
      logic [7:0] raw_resolution;
      logic [7:0] jpeg_resolution;
      logic [7:0] package_payload;
   } cfg_type;

   // multi: six transmit beats from bytes; else one beat of kind/bytes[0]/evt
   typedef struct packed {
      logic        multi;
      logic [1:0]  kind;
      logic [2:0]  evt;
      logic [23:0] length;
      cmd_type     bytes;
   } job_type;

   // expected reply byte; zero is a wildcard
   function automatic logic [7:0] reply_byte(input logic [3:0] ph, input logic [2:0] pos);
      logic [7:0] b;
      b = 8'h00;
      case (pos)
         3'd0: b = BYTE_SYNC_HDR;
         3'd1: b = (ph == PH_SYNC_EXT) ? ID_SYNC : ID_ACK;
         3'd2: begin
            case (ph)
               PH_SYNC_ACK: b = ID_SYNC;
               PH_PACK_ACK: b = ID_PKG_SIZE;
               PH_SNAP_ACK: b = ID_SNAPSHOT;
               PH_PIC_ACK:  b = ID_GET_PIC;
               default:     b = 8'h00;
            endcase
         end
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // payload register limited to 1..249
   function automatic logic [7:0] clamp_payload(input logic [7:0] p);
      logic [7:0] r;
      r = p;
      if (p == 8'd0) r = 8'd1;
      else if (p > 8'd249) r = 8'd249;
      return r;
   endfunction

endpackage

// ===== hw/rtl/scch_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scch_front
// Accepts input beats, runs the protocol phases and emits one job per beat
// that has results.
// ----------------------------------------------------------------------------
module scch_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  scch_pkg::req_type req_data,
   input  scch_pkg::cfg_type cfg,
   output logic              job_valid,
   output scch_pkg::job_type job,
   input  logic              job_ready
);
   import scch_pkg::*;

   logic [3:0]  phase_ff, phase_in;
   logic [2:0]  mpos_ff, mpos_in;
   logic [23:0] remain_ff, remain_in;
   logic [23:0] size_ff, size_in;
   logic [15:0] pkg_num_ff, pkg_num_in;
   logic [8:0]  pkg_idx_ff, pkg_idx_in;
   logic [8:0]  pkg_len_ff, pkg_len_in;
   logic [7:0]  size_b0_ff, size_b0_in;
   logic [7:0]  size_b1_ff, size_b1_in;

   logic        accept;
   logic [7:0]  rx;
   logic [7:0]  pay;
   logic [2:0]  pos;
   logic [2:0]  pos_next;
   logic [7:0]  want;
   logic [8:0]  idx_next;
   logic        data_ok;
   logic [23:0] remain_dec;
   logic [23:0] new_size;
   logic [7:0]  chunk;

   assign req_ready = job_ready;
   assign accept    = req_valid && req_ready;
   assign rx        = req_data.rx_byte;
   assign pay       = clamp_payload(cfg.package_payload);

   function automatic cmd_type stage_cmd(input logic [3:0] ph, input cfg_type c,
                                         input logic [7:0] p);
      cmd_type r;
      r    = '0;
      r[0] = BYTE_SYNC_HDR;
      case (ph)
         PH_INIT_ACK: begin
            r[1] = ID_INITIAL;
            r[3] = c.color_format;
            r[4] = c.raw_resolution;
            r[5] = c.jpeg_resolution;
         end
         PH_PACK_ACK: begin
            r[1] = ID_PKG_SIZE;
            r[2] = 8'h08;
            r[3] = p + 8'd6;
         end
         PH_SNAP_ACK: r[1] = ID_SNAPSHOT;
         default: begin
            r[1] = ID_GET_PIC;
            r[2] = 8'h01;
         end
      endcase
      return r;
   endfunction

   function automatic job_type cmd_job(input cmd_type b);
      job_type j;
      j       = '0;
      j.multi = 1'b1;
      j.kind  = KIND_TX;
      j.bytes = b;
      return j;
   endfunction

   function automatic job_type event_job(input logic [2:0] ev, input logic [23:0] len);
      job_type j;
      j        = '0;
      j.kind   = KIND_EVENT;
      j.evt    = ev;
      j.length = len;
      return j;
   endfunction

   always_comb begin
      pos       = (mpos_ff < 3'd6) ? mpos_ff : 3'd0;
      want      = reply_byte(phase_ff, pos);
      pos_next  = pos + 3'd1;
      idx_next  = pkg_idx_ff + 9'd1;
      data_ok   = (pkg_idx_ff >= 9'd4) && ({1'b0, pkg_idx_ff} + 10'd2 < {1'b0, pkg_len_ff});
      remain_dec = (data_ok && remain_ff != 24'd0) ? remain_ff - 24'd1 : remain_ff;
      new_size  = {rx, size_b1_ff, size_b0_ff};
      chunk     = (remain_ff < {16'd0, pay}) ? remain_ff[7:0] : pay;
   end

   always_comb begin
      phase_in   = phase_ff;
      mpos_in    = mpos_ff;
      remain_in  = remain_ff;
      size_in    = size_ff;
      pkg_num_in = pkg_num_ff;
      pkg_idx_in = pkg_idx_ff;
      pkg_len_in = pkg_len_ff;
      size_b0_in = size_b0_ff;
      size_b1_in = size_b1_ff;
      job_valid  = 1'b0;
      job        = '0;
      if (accept) begin
         case (req_data.opcode)
            OP_SYNC: begin
               job_valid = 1'b1;
               job       = cmd_job({8'h00, 8'h00, 8'h00, 8'h00, ID_SYNC, BYTE_SYNC_HDR});
               phase_in  = PH_SYNC_ACK;
               mpos_in   = 3'd0;
            end
            OP_CAPTURE: begin
               job_valid = 1'b1;
               job       = cmd_job(stage_cmd(PH_INIT_ACK, cfg, pay));
               phase_in  = PH_INIT_ACK;
               mpos_in   = 3'd0;
            end
            OP_NEXT: begin
               job_valid = 1'b1;
               if (phase_ff != PH_READY) begin
                  job = event_job(EV_REFUSED, size_ff);
               end else if (remain_ff == 24'd0) begin
                  job = event_job(EV_IMAGE, size_ff);
               end else begin
                  job = cmd_job({pkg_num_ff[15:8], pkg_num_ff[7:0], 8'h00, 8'h00,
                                 ID_ACK, BYTE_SYNC_HDR});
                  pkg_len_in = {1'b0, chunk} + 9'd6;
                  pkg_idx_in = 9'd0;
                  phase_in   = PH_STREAM;
               end
            end
            default: begin
               case (phase_ff)
                  PH_SYNC_ACK, PH_SYNC_EXT, PH_INIT_ACK,
                  PH_PACK_ACK, PH_SNAP_ACK, PH_PIC_ACK: begin
                     if (want == 8'h00 || want == rx) begin
                        mpos_in = pos_next;
                        if (pos_next == 3'd6) begin
                           mpos_in = 3'd0;
                           case (phase_ff)
                              PH_SYNC_EXT: begin
                                 job_valid = 1'b1;
                                 job       = cmd_job({8'h00, BYTE_SYNC_OK, 8'h00, 8'h00,
                                                      ID_ACK, BYTE_SYNC_HDR});
                                 phase_in  = PH_IDLE;
                              end
                              PH_SYNC_ACK: phase_in = PH_SYNC_EXT;
                              PH_PIC_ACK:  phase_in = PH_SIZE;
                              default: begin
                                 job_valid = 1'b1;
                                 job       = cmd_job(stage_cmd(phase_ff + 4'd1, cfg, pay));
                                 phase_in  = phase_ff + 4'd1;
                              end
                           endcase
                        end
                     end else begin
                        mpos_in = pos;
                     end
                  end
                  PH_SIZE: begin
                     if (pos == 3'd3) size_b0_in = rx;
                     if (pos == 3'd4) size_b1_in = rx;
                     mpos_in = pos_next;
                     if (pos_next == 3'd6) begin
                        mpos_in    = 3'd0;
                        size_in    = new_size;
                        remain_in  = new_size;
                        pkg_num_in = 16'd0;
                        job_valid  = 1'b1;
                        if (new_size != 24'd0) begin
                           phase_in = PH_READY;
                           job      = event_job(EV_READY, new_size);
                        end else begin
                           phase_in = PH_IDLE;
                           job      = event_job(EV_SIZE_ZERO, new_size);
                        end
                     end
                  end
                  PH_STREAM: begin
                     remain_in  = remain_dec;
                     pkg_idx_in = idx_next;
                     if (data_ok) begin
                        job_valid   = 1'b1;
                        job         = '0;
                        job.kind    = KIND_DATA;
                        job.bytes[0] = rx;
                     end
                     // a package never ends on a payload byte
                     if (idx_next >= pkg_len_ff) begin
                        pkg_num_in = pkg_num_ff + 16'd1;
                        phase_in   = PH_READY;
                        job_valid  = 1'b1;
                        if (remain_dec == 24'd0) begin
                           job = cmd_job({BYTE_BYE, BYTE_BYE, 8'h00, 8'h00,
                                          ID_ACK, BYTE_SYNC_HDR});
                        end else begin
                           job = event_job(EV_PACKAGE, size_ff);
                        end
                     end
                  end
                  default: ;
               endcase
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         mpos_ff    <= 3'd0;
         remain_ff  <= 24'd0;
         size_ff    <= 24'd0;
         pkg_num_ff <= 16'd0;
         pkg_idx_ff <= 9'd0;
         pkg_len_ff <= 9'd0;
         size_b0_ff <= 8'd0;
         size_b1_ff <= 8'd0;
      end else begin
         phase_ff   <= phase_in;
         mpos_ff    <= mpos_in;
         remain_ff  <= remain_in;
         size_ff    <= size_in;
         pkg_num_ff <= pkg_num_in;
         pkg_idx_ff <= pkg_idx_in;
         pkg_len_ff <= pkg_len_in;
         size_b0_ff <= size_b0_in;
         size_b1_ff <= size_b1_in;
      end
   end

endmodule

// ===== hw/rtl/scch_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scch_queue
// Short job queue between the protocol front and the result sequencer.
// ----------------------------------------------------------------------------
module scch_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  scch_pkg::job_type in_job,
   output logic              out_valid,
   input  logic              out_ready,
   output scch_pkg::job_type out_job
);
   import scch_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type             entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                push;
   logic                pop;

   assign in_ready  = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_job   = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= in_job;
   end

endmodule

// ===== hw/rtl/scch_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scch_back
// Result sequencer: plays each job out as one or six result beats.
// ----------------------------------------------------------------------------
module scch_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_ready,
   input  scch_pkg::job_type job,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output scch_pkg::rsp_type rsp_data
);
   import scch_pkg::*;

   localparam int IDX_W = $clog2(CMD_LEN);

   job_type          cur_ff, cur_in;
   logic             active_ff, active_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             last;

   assign last      = !cur_ff.multi || (idx_ff == IDX_W'(CMD_LEN - 1));
   assign job_ready = !active_ff || (rsp_ready && last);
   assign rsp_valid = active_ff;

   always_comb begin
      rsp_data.out_kind     = cur_ff.multi ? KIND_TX : cur_ff.kind;
      rsp_data.out_byte     = cur_ff.bytes[idx_ff];
      rsp_data.event_code   = cur_ff.multi ? EV_NONE : cur_ff.evt;
      rsp_data.image_length = cur_ff.multi ? 24'd0 : cur_ff.length;
      rsp_data.run_last     = last;
   end

   always_comb begin
      cur_in    = cur_ff;
      active_in = active_ff;
      idx_in    = idx_ff;
      if (job_ready) begin
         active_in = job_valid;
         cur_in    = job;
         idx_in    = '0;
      end else if (rsp_ready) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         idx_ff    <= '0;
      end else begin
         active_ff <= active_in;
         idx_ff    <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

endmodule

// ===== hw/rtl/serial_camera_capture_host_unit.sv =====
`timescale 1ns / 1ps
// An accepted job is registered in the job queue, then in the result
// sequencer. Throughput: one result beat per cycle while rsp_ready is high;
//   a command item gives six transmit beats, an event or data item one.
// The two-entry job queue lets input beats arrive while commands are played out.
// Reset: synchronous, active high; clears phases, counters, queue; presets regs.
// ----------------------------------------------------------------------------
// serial_camera_capture_host_unit
// Host side of a six-byte command serial camera link, with APB registers.
// ----------------------------------------------------------------------------
module serial_camera_capture_host_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  scch_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output scch_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [3:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import scch_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    cfg_wr;
   logic    fq_valid, fq_ready;
   job_type fq_job;
   logic    qb_valid, qb_ready;
   job_type qb_job;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_wr) begin
         case (paddr[3:2])
            REG_COLOR_FORMAT:    cfg_in.color_format    = pwdata[7:0];
            REG_RAW_RESOLUTION:  cfg_in.raw_resolution  = pwdata[7:0];
            REG_JPEG_RESOLUTION: cfg_in.jpeg_resolution = pwdata[7:0];
            REG_PACKAGE_PAYLOAD: cfg_in.package_payload = pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_COLOR_FORMAT:    prdata = {24'd0, cfg_ff.color_format};
         REG_RAW_RESOLUTION:  prdata = {24'd0, cfg_ff.raw_resolution};
         REG_JPEG_RESOLUTION: prdata = {24'd0, cfg_ff.jpeg_resolution};
         REG_PACKAGE_PAYLOAD: prdata = {24'd0, cfg_ff.package_payload};
         default:             prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.color_format    <= 8'd7;
         cfg_ff.raw_resolution  <= 8'd9;
         cfg_ff.jpeg_resolution <= 8'd7;
         cfg_ff.package_payload <= 8'd64;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   scch_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .job_valid (fq_valid),
      .job       (fq_job),
      .job_ready (fq_ready)
   );

   scch_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_job    (fq_job),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_job   (qb_job)
   );

   scch_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (qb_valid),
      .job_ready (qb_ready),
      .job       (qb_job),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hw/rtl/scch_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scch_checker
// Port-level checks of the serial camera capture host, bound to the top.
// ----------------------------------------------------------------------------
`include "serial_camera_capture_host_unit_defines.svh"

module scch_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input scch_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input scch_pkg::rsp_type rsp_data,
   input logic              psel,
   input logic              penable,
   input logic              pwrite,
   input logic [3:0]        paddr,
   input logic [31:0]       pwdata,
   input logic [31:0]       prdata,
   input logic              pready
);
   import scch_pkg::*;

   logic tx_more;
   logic event_beat;

   assign tx_more    = rsp_valid && rsp_ready && rsp_data.out_kind == KIND_TX
                       && !rsp_data.run_last;
   assign event_beat = rsp_valid && rsp_data.out_kind == KIND_EVENT;

   // a result beat waits for its taker
   `SCCH_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid)

   // nothing is left pending out of reset
   `SCCH_ASSERT_ALWAYS(a_reset_clear, reset |=> !rsp_valid)

   // a status event is always the only result of its item
   `SCCH_ASSERT(a_event_last, event_beat |-> rsp_data.run_last)

   // a command keeps going with transmit beats until its last byte
   `SCCH_ASSERT(a_cmd_cont, tx_more |=> rsp_valid && rsp_data.out_kind == KIND_TX)

endmodule

bind serial_camera_capture_host_unit scch_checker u_checker (.*);

// ===== dv/camera_host_check_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// camera_host_check_pkg
// Protocol predictor and result scoreboard for the serial camera capture host.
// Tracks the host's handshake phase, reply matching, image size and package
// streaming, and keeps the result beats each request beat should produce.
// ----------------------------------------------------------------------------
package camera_host_check_pkg;
   import scch_pkg::*;

   localparam logic [7:0] ANY_BYTE     = 8'h00;   // wildcard in a reply pattern
   localparam logic [7:0] PKG_SIZE_TAG = 8'h08;
   localparam logic [7:0] PIC_SNAPSHOT = 8'h01;
   localparam int         MAX_PRINTED  = 30;

   // byte the host waits for at a given position of a reply
   function automatic logic [7:0] reply_want(input logic [3:0] ph, input int pos);
      logic [7:0] pat [6];
      pat = '{BYTE_SYNC_HDR, ID_ACK, ANY_BYTE, ANY_BYTE, ANY_BYTE, ANY_BYTE};
      case (ph)
         PH_SYNC_ACK: pat[2] = ID_SYNC;
         PH_SYNC_EXT: pat[1] = ID_SYNC;
         PH_PACK_ACK: pat[2] = ID_PKG_SIZE;
         PH_SNAP_ACK: pat[2] = ID_SNAPSHOT;
         PH_PIC_ACK:  pat[2] = ID_GET_PIC;
         default: ;
      endcase
      return pat[pos];
   endfunction

   class camera_host_scoreboard;
      cfg_type     regs;
      logic [3:0]  phase;
      int          match_pos;
      logic [23:0] bytes_left;
      logic [23:0] image_size;
      logic [15:0] pkg_num;
      int          pkg_idx;
      int          pkg_len;
      logic [7:0]  size_bytes [3];
      rsp_type     awaited_beats [$];
      rsp_type     step_beats [$];
      int          errors;
      int          beats_checked;

      function new();
         regs.color_format    = 8'd7;
         regs.raw_resolution  = 8'd9;
         regs.jpeg_resolution = 8'd7;
         regs.package_payload = 8'd64;
         phase      = PH_IDLE;
         match_pos  = 0;
         bytes_left = '0;
         image_size = '0;
         pkg_num    = '0;
         pkg_idx    = 0;
         pkg_len    = 0;
         size_bytes = '{8'h00, 8'h00, 8'h00};
         errors     = 0;
         beats_checked = 0;
      endfunction

      function void set_reg(input logic [1:0] idx, input logic [7:0] val);
         case (idx)
            REG_COLOR_FORMAT:    regs.color_format    = val;
            REG_RAW_RESOLUTION:  regs.raw_resolution  = val;
            REG_JPEG_RESOLUTION: regs.jpeg_resolution = val;
            default:             regs.package_payload = val;
         endcase
      endfunction

      function int eff_payload();
         if (regs.package_payload == 8'd0) return 1;
         if (regs.package_payload > 8'd249) return 249;
         return int'(regs.package_payload);
      endfunction

      function int pending();
         return awaited_beats.size();
      endfunction

      function void add_beat(input logic [1:0] kind, input logic [7:0] data,
                             input logic [2:0] ev, input logic [23:0] len);
         rsp_type b;
         b.out_kind     = kind;
         b.out_byte     = data;
         b.event_code   = ev;
         b.image_length = len;
         b.run_last     = 1'b0;
         step_beats.push_back(b);
      endfunction

      function void add_cmd(input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
                            input logic [7:0] b3, input logic [7:0] b4, input logic [7:0] b5);
         logic [7:0] c [6];
         c = '{b0, b1, b2, b3, b4, b5};
         foreach (c[k]) add_beat(KIND_TX, c[k], EV_NONE, 24'd0);
      endfunction

      function void add_event(input logic [2:0] ev);
         add_beat(KIND_EVENT, 8'h00, ev, image_size);
      endfunction

      // command that opens the step waiting in phase ph
      function void send_stage(input logic [3:0] ph);
         case (ph)
            PH_INIT_ACK: add_cmd(BYTE_SYNC_HDR, ID_INITIAL, 8'h00, regs.color_format,
                                 regs.raw_resolution, regs.jpeg_resolution);
            PH_PACK_ACK: add_cmd(BYTE_SYNC_HDR, ID_PKG_SIZE, PKG_SIZE_TAG,
                                 8'(eff_payload() + 6), 8'h00, 8'h00);
            PH_SNAP_ACK: add_cmd(BYTE_SYNC_HDR, ID_SNAPSHOT, 8'h00, 8'h00, 8'h00, 8'h00);
            default:     add_cmd(BYTE_SYNC_HDR, ID_GET_PIC, PIC_SNAPSHOT, 8'h00, 8'h00, 8'h00);
         endcase
      endfunction

      // camera byte; returns 0 when the host ignores it
      function bit take_byte(input logic [7:0] rx);
         logic [7:0] want;
         int i;
         if (phase >= PH_SYNC_ACK && phase <= PH_PIC_ACK) begin
            want = reply_want(phase, match_pos);
            if (want == ANY_BYTE || want == rx) match_pos++;
            if (match_pos == CMD_LEN) begin
               match_pos = 0;
               case (phase)
                  PH_SYNC_EXT: begin
                     add_cmd(BYTE_SYNC_HDR, ID_ACK, 8'h00, 8'h00, BYTE_SYNC_OK, 8'h00);
                     phase = PH_IDLE;
                  end
                  PH_SYNC_ACK: phase = PH_SYNC_EXT;
                  PH_PIC_ACK:  phase = PH_SIZE;
                  default: begin
                     phase = phase + 4'd1;
                     send_stage(phase);
                  end
               endcase
            end
            return 1'b1;
         end
         if (phase == PH_SIZE) begin
            // DATA reply: last three bytes carry the size, LSB first
            if (match_pos >= 3) size_bytes[match_pos - 3] = rx;
            match_pos++;
            if (match_pos == CMD_LEN) begin
               match_pos  = 0;
               image_size = {size_bytes[2], size_bytes[1], size_bytes[0]};
               bytes_left = image_size;
               pkg_num    = '0;
               if (image_size != 0) begin
                  phase = PH_READY;
                  add_event(EV_READY);
               end else begin
                  phase = PH_IDLE;
                  add_event(EV_SIZE_ZERO);
               end
            end
            return 1'b1;
         end
         if (phase == PH_STREAM) begin
            i = pkg_idx;
            // 4 header and 2 trailer bytes are dropped
            if (i >= 4 && i + 2 < pkg_len) begin
               add_beat(KIND_DATA, rx, EV_NONE, 24'd0);
               if (bytes_left != 0) bytes_left--;
            end
            pkg_idx = (i + 1) & 9'h1FF;
            if (pkg_idx >= pkg_len) begin
               pkg_num++;
               phase = PH_READY;
               if (bytes_left == 0)
                  add_cmd(BYTE_SYNC_HDR, ID_ACK, 8'h00, 8'h00, BYTE_BYE, BYTE_BYE);
               else
                  add_event(EV_PACKAGE);
            end
            return 1'b1;
         end
         return 1'b0;
      endfunction

      // note an accepted request beat; returns 0 when the host ignores it
      function bit accept_request(input req_type r);
         rsp_type last;
         bit engaged;
         int p;
         step_beats.delete();
         engaged = 1'b1;
         p = eff_payload();
         case (r.opcode)
            OP_SYNC: begin
               add_cmd(BYTE_SYNC_HDR, ID_SYNC, 8'h00, 8'h00, 8'h00, 8'h00);
               phase = PH_SYNC_ACK;
               match_pos = 0;
            end
            OP_CAPTURE: begin
               send_stage(PH_INIT_ACK);
               phase = PH_INIT_ACK;
               match_pos = 0;
            end
            OP_NEXT: begin
               if (phase != PH_READY) begin
                  add_event(EV_REFUSED);
               end else if (bytes_left == 0) begin
                  add_event(EV_IMAGE);
               end else begin
                  add_cmd(BYTE_SYNC_HDR, ID_ACK, 8'h00, 8'h00, pkg_num[7:0], pkg_num[15:8]);
                  pkg_len = ((bytes_left < p) ? int'(bytes_left) : p) + 6;
                  pkg_idx = 0;
                  phase = PH_STREAM;
               end
            end
            default: engaged = take_byte(r.rx_byte);
         endcase
         if (step_beats.size() > 0) begin
            last = step_beats.pop_back();
            last.run_last = 1'b1;
            step_beats.push_back(last);
         end
         foreach (step_beats[k]) awaited_beats.push_back(step_beats[k]);
         return engaged;
      endfunction

      task report_mismatch(input string msg);
         errors++;
         // later mismatches are only counted
         if (errors <= MAX_PRINTED) $display("mismatch: %s", msg);
      endtask

      task check_beat(input rsp_type got);
         rsp_type want;
         beats_checked++;
         if (awaited_beats.size() == 0) begin
            report_mismatch($sformatf("result beat %h with nothing awaited", got));
            return;
         end
         want = awaited_beats.pop_front();
         if (got.out_kind !== want.out_kind)
            report_mismatch($sformatf("beat %0d out_kind %0d, want %0d",
                                      beats_checked, got.out_kind, want.out_kind));
         if (got.out_byte !== want.out_byte)
            report_mismatch($sformatf("beat %0d out_byte %h, want %h",
                                      beats_checked, got.out_byte, want.out_byte));
         if (got.event_code !== want.event_code)
            report_mismatch($sformatf("beat %0d event_code %0d, want %0d",
                                      beats_checked, got.event_code, want.event_code));
         if (got.image_length !== want.image_length)
            report_mismatch($sformatf("beat %0d image_length %h, want %h",
                                      beats_checked, got.image_length, want.image_length));
         if (got.run_last !== want.run_last)
            report_mismatch($sformatf("beat %0d run_last %b, want %b",
                                      beats_checked, got.run_last, want.run_last));
      endtask
   endclass

endpackage

// ===== dv/serial_camera_capture_host_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_camera_capture_host_unit_test
// Drives sync and capture handshakes, camera replies with skipped bytes,
// package streaming and stray requests into the camera host, under four
// register settings and several idle/stall mixes, and checks every result beat.
// ----------------------------------------------------------------------------
module serial_camera_capture_host_unit_test;
   import scch_pkg::*;
   import camera_host_check_pkg::*;

   localparam int DRAIN_CYCLES = 20;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   int send_idle_pct;
   int recv_stall_pct;
   int hold_left;
   int counted_items;
   int total_items;
   int images_full;

   camera_host_scoreboard sb = new();

   serial_camera_capture_host_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

   // result side: check accepted beats, stall at random or hold off on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) sb.check_beat(rsp_data);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   task automatic send_item(input logic [1:0] op, input logic [7:0] rx);
      req_type item;
      item.opcode  = op;
      item.rx_byte = rx;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      total_items++;
      if (sb.accept_request(item)) counted_items++;
   endtask

   // well-formed reply, wildcards random, now and then a skipped stray byte
   task automatic send_reply(input logic [3:0] ph);
      logic [7:0] want;
      logic [7:0] junk;
      for (int pos = 0; pos < CMD_LEN; pos++) begin
         want = reply_want(ph, pos);
         if (want != ANY_BYTE && $urandom_range(99) < 12) begin
            junk = 8'($urandom);
            if (junk == want) junk = ~want;
            send_item(OP_RX, junk);
         end
         send_item(OP_RX, (want == ANY_BYTE) ? 8'($urandom) : want);
      end
   endtask

   task automatic run_sync();
      send_item(OP_SYNC, 8'($urandom));
      send_reply(PH_SYNC_ACK);
      send_reply(PH_SYNC_EXT);
   endtask

   task automatic run_capture();
      logic [23:0] size;
      int p, lim, left, n, len, roll;
      bit wide_size, give_up;
      p = sb.eff_payload();
      lim = (3 * p + 2 < 12) ? 3 * p + 2 : 12;
      roll = $urandom_range(99);
      wide_size = (roll >= 15 && roll < 25);
      if (roll < 15) size = '0;
      else if (wide_size) size = 24'($urandom);
      else size = 24'($urandom_range(1, lim));
      send_item(OP_CAPTURE, 8'($urandom));
      send_reply(PH_INIT_ACK);
      send_reply(PH_PACK_ACK);
      send_reply(PH_SNAP_ACK);
      send_reply(PH_PIC_ACK);
      for (int k = 0; k < 3; k++) send_item(OP_RX, 8'($urandom));
      send_item(OP_RX, size[7:0]);
      send_item(OP_RX, size[15:8]);
      send_item(OP_RX, size[23:16]);
      if (size == 0) return;
      // wide sizes and some others are dropped partway through a package
      give_up = wide_size || ($urandom_range(99) < 20);
      left = int'(size);
      while (left > 0) begin
         n = (left < p) ? left : p;
         len = n + 6;
         if (give_up) len = $urandom_range(0, (len < 12) ? len : 12);
         send_item(OP_NEXT, 8'($urandom));
         for (int k = 0; k < len; k++) send_item(OP_RX, 8'($urandom));
         if (give_up) return;
         left -= n;
      end
      send_item(OP_NEXT, 8'($urandom));
      images_full++;
   endtask

   task automatic run_phase(input int quota);
      int target;
      int roll;
      target = total_items + quota;
      while (total_items < target) begin
         roll = $urandom_range(99);
         if (roll < 25) run_sync();
         else if (roll < 80) run_capture();
         else send_item(2'($urandom), 8'($urandom));
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {24'd0, val};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      sb.set_reg(idx, val);
      // read back
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata[7:0] !== val)
         sb.report_mismatch($sformatf("register %0d reads %h, want %h", idx, prdata[7:0], val));
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_all(input logic [7:0] color, input logic [7:0] raw,
                            input logic [7:0] jpeg, input logic [7:0] payload);
      write_reg(REG_COLOR_FORMAT, color);
      write_reg(REG_RAW_RESOLUTION, raw);
      write_reg(REG_JPEG_RESOLUTION, jpeg);
      write_reg(REG_PACKAGE_PAYLOAD, payload);
   endtask

   task automatic run_directed();
      logic [7:0] seq [$];
      send_item(OP_NEXT, 8'hFF);          // refused from idle
      send_item(OP_RX, 8'hFF);            // ignored in idle
      send_item(OP_SYNC, 8'h00);
      // first byte is no header: skipped
      seq = '{8'h00, BYTE_SYNC_HDR, ID_ACK, ID_SYNC, 8'h00, 8'hFF, 8'h5A};
      foreach (seq[i]) send_item(OP_RX, seq[i]);
      send_item(OP_NEXT, 8'h00);          // refused mid-handshake
      seq = '{BYTE_SYNC_HDR, ID_SYNC, 8'hFF, 8'h00, 8'hA5, 8'hFF};
      foreach (seq[i]) send_item(OP_RX, seq[i]);
      send_item(OP_CAPTURE, 8'hFF);
      send_item(OP_RX, BYTE_SYNC_HDR);
      send_item(OP_SYNC, 8'h00);          // restart while busy
      send_item(OP_CAPTURE, 8'h00);
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_left      = 0;
      counted_items  = 0;
      total_items    = 0;
      images_full    = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values, no idling
      run_directed();
      run_phase(15);
      drain();

      // all zero, payload acts as one byte
      write_all(8'h00, 8'h00, 8'h00, 8'h00);
      send_idle_pct = 49;
      run_phase(15);
      drain();

      // all ones, payload clamps; long output hold fills the block
      write_all(8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_idle_pct  = 0;
      recv_stall_pct = 49;
      hold_left      = 300;
      run_phase(15);
      drain();

      write_all(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom_range(2, 10)));
      send_idle_pct  = 27;
      recv_stall_pct = 27;
      run_phase(15);
      drain();

      $display("run: %0d request beats (%0d acted on), %0d result beats, %0d full images",
               total_items, counted_items, sb.beats_checked, images_full);
      $display("run: four register settings incl. all-zero and all-ones, mixed idle and stall");
      if (sb.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
